[rtl/rdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types and constants of the repeater duplicate filter.
// ----------------------------------------------------------------------------
package rdf_pkg;

	// Default number of entries in the recent-transaction table.
	localparam int unsigned DEF_TABLE_DEPTH = 16;

	// Configuration register indexes and the width of the write port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HOP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPIRE_MS = 2'd3;

	// Register values after reset.
	localparam logic        RST_ENABLE    = 1'b0;
	localparam logic [3:0]  RST_MAX_HOP   = 4'd4;
	localparam logic [7:0]  RST_DEV_ADDR  = 8'd1;
	localparam logic [31:0] RST_EXPIRE_MS = 32'd5000;

	// Header fields of one received packet.
	typedef struct packed {
		logic [7:0]  dest_addr;
		logic [3:0]  hop;
		logic [7:0]  reg_addr;
		logic [7:0]  func_code;
		logic [7:0]  packet_seq;
		logic [31:0] now_ms;
	} in_t;

	// Decision for one packet.
	typedef struct packed {
		logic        repeat_res;
		logic [3:0]  out_hop;
		logic [7:0]  out_src_addr;
	} out_t;

	// One entry of the recent-transaction table.
	typedef struct packed {
		logic        valid;
		logic [7:0]  reg_addr;
		logic [7:0]  func_code;
		logic [7:0]  packet_seq;
		logic [31:0] time_ms;
	} entry_t;

endpackage

[rtl/repeater_duplicate_filter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeater_duplicate_filter_unit
// Decides whether a flooding repeater retransmits a received packet.
// ----------------------------------------------------------------------------
// A packet is taken when start is high and busy is low. In turn, its header is
// registered, every table cell compares its entry with it, and the cell results
// are combined, the decision is made and, on a repeat, the table shifts one
// place with the packet written at the head. The result appears on the cycle
// after that, for one cycle only with done high, and must be taken then: the
// receiver cannot stall. busy is already low in that cycle, so a new packet may
// start at once; none is taken while one is in flight. The user must write the
// configuration registers through wr_en, wr_index and wr_data only while the
// block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module repeater_duplicate_filter_unit
	import rdf_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_t                   packet,
	output logic                  done,
	output out_t                  result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_DECIDE
	} state_t;

	state_t            state_q;
	in_t               pkt_s1;
	logic              enable_q;
	logic [3:0]        max_hop_q;
	logic [7:0]        dev_addr_q;
	logic [31:0]       expire_ms_q;
	logic              done_q;
	out_t              result_q;
	logic              accept;
	logic              shift;
	logic              any_hit;
	logic              rep;
	entry_t            head_entry;
	entry_t            chain [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] hits;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= RST_ENABLE;
			max_hop_q   <= RST_MAX_HOP;
			dev_addr_q  <= RST_DEV_ADDR;
			expire_ms_q <= RST_EXPIRE_MS;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLE:    enable_q    <= wr_data[0];
				REG_MAX_HOP:   max_hop_q   <= wr_data[3:0];
				REG_DEV_ADDR:  dev_addr_q  <= wr_data[7:0];
				REG_EXPIRE_MS: expire_ms_q <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	// Packet header register.
	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_s1 <= packet;
		end
	end

	// Decision from the registered cell results.
	assign any_hit = |hits;
	assign rep     = enable_q && (pkt_s1.dest_addr != dev_addr_q) &&
		(pkt_s1.hop < max_hop_q) && !any_hit;
	assign shift   = (state_q == ST_DECIDE) && rep;

	// New head entry written on a repeat.
	assign head_entry.valid      = 1'b1;
	assign head_entry.reg_addr   = pkt_s1.reg_addr;
	assign head_entry.func_code  = pkt_s1.func_code;
	assign head_entry.packet_seq = pkt_s1.packet_seq;
	assign head_entry.time_ms    = pkt_s1.now_ms;
	assign chain[0]              = head_entry;

	// Row of table cells; each passes its entry to the next on a shift.
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		rdf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.entry_in  (chain[g]),
			.probe     (pkt_s1),
			.expire_ms (expire_ms_q),
			.entry_out (chain[g+1]),
			.hit       (hits[g])
		);
	end

	// Sequencer with the registered result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q                <= ST_IDLE;
					done_q                 <= 1'b1;
					result_q.repeat_res    <= rep;
					result_q.out_hop       <= rep ? 4'(pkt_s1.hop + 4'd1) : 4'd0;
					result_q.out_src_addr  <= rep ? dev_addr_q : 8'd0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result transaction follows only the decision step.
	a_done_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DECIDE)
		else $error("result without a decision step");

	// A packet taken keeps the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted packet did not make the block busy");

	// A packet that is not repeated gives zero fields.
	a_no_repeat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.repeat_res) |-> (result.out_hop == 4'd0 &&
		result.out_src_addr == 8'd0))
		else $error("non-repeat result carries non-zero fields");

	// After a repeat the head of the table holds a valid entry.
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		shift |=> chain[1].valid)
		else $error("table head not valid after a repeat");

endmodule

[rtl/rdf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdf_cell
// One place of the recent-transaction table: holds an entry, compares it with
// the packet under test and hands it on to the next place on a shift.
// ----------------------------------------------------------------------------
module rdf_cell
	import rdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift,
	input  entry_t      entry_in,
	input  in_t         probe,
	input  logic [31:0] expire_ms,
	output entry_t      entry_out,
	output logic        hit
);

	entry_t      entry_q;
	logic        hit_q;
	logic [31:0] age;
	logic        match;

	// Age wraps modulo 2^32; a matching entry younger than the expiry suppresses.
	assign age   = probe.now_ms - entry_q.time_ms;
	assign match = entry_q.valid &&
		(entry_q.reg_addr == probe.reg_addr) &&
		(entry_q.func_code == probe.func_code) &&
		(entry_q.packet_seq == probe.packet_seq) &&
		(age < expire_ms);

	// The entry and the compare result are cleared at reset; the whole entry,
	// valid bit and payload together, moves on a shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			hit_q <= match;
			if (shift) begin
				entry_q <= entry_in;
			end
		end
	end

	assign entry_out = entry_q;
	assign hit       = hit_q;

endmodule
